[rtl/core/ktrsq_pkg.sv]
// ----------------------------------------------------------------------------
// ktrsq_pkg: shared types and constants of the k-ary range sum query block
// Item and result structs, controller codes, tree geometry helpers.
// ----------------------------------------------------------------------------
package ktrsq_pkg;

	// tree geometry
	localparam int BRANCH     = 4;
	localparam int MAX_LEAVES = 1024;
	localparam int MAX_LEVELS = 6;

	// field widths
	localparam int LEAF_W  = 11;
	localparam int LVL_W   = 3;
	localparam int IDX_W   = 10;
	localparam int REAL_W  = 24;
	localparam int NOISE_W = 24;
	localparam int SUM_W   = 32;
	localparam int CELL_W  = REAL_W + NOISE_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEAF_W;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = CFG_IDX_W'(1);
	localparam logic [LEAF_W-1:0]    LEAF_RESET      = LEAF_W'(MAX_LEAVES);
	localparam logic [LVL_W-1:0]     LEVEL_RESET     = LVL_W'(MAX_LEVELS);

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// accumulator width: every node of the range at most once
	localparam int ACC_W = REAL_W + $clog2(MAX_LEAVES) + 1;

	localparam logic [IDX_W-1:0] BRANCH_IDX  = IDX_W'(BRANCH);
	localparam logic [IDX_W-1:0] BRANCH_LAST = IDX_W'(BRANCH - 1);

	// largest node count of a level, for storage layout
	function automatic int max_nodes(input int lvl);
		int n;
		n = MAX_LEAVES;
		for (int j = 0; j < lvl; j++) begin
			n = (n + BRANCH - 1) / BRANCH;
		end
		return n;
	endfunction

	function automatic int store_depth();
		int d;
		d = 0;
		for (int j = 0; j < MAX_LEVELS; j++) begin
			d = d + max_nodes(j);
		end
		return d;
	endfunction

	localparam int STORE_DEPTH = store_depth();
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// first store entry of a level
	function automatic logic [ADDR_W-1:0] base_of(input logic [LVL_W-1:0] lvl);
		logic [ADDR_W-1:0] b;
		b = '0;
		for (int j = 0; j < MAX_LEVELS; j++) begin
			if (LVL_W'(j) < lvl) begin
				b = b + ADDR_W'(max_nodes(j));
			end
		end
		return b;
	endfunction

	// node count of a level for the leaf count in use
	function automatic logic [LEAF_W-1:0] nodes_at(input logic [LEAF_W-1:0] leaves,
			input logic [LVL_W-1:0] lvl);
		logic [LEAF_W-1:0] n;
		n = leaves;
		for (int j = 0; j < MAX_LEVELS - 1; j++) begin
			if (LVL_W'(j) < lvl) begin
				n = (n + LEAF_W'(BRANCH - 1)) / LEAF_W'(BRANCH);
			end
		end
		return n;
	endfunction

	typedef struct packed {
		logic                      kind;
		logic [LVL_W-1:0]          node_level;
		logic [IDX_W-1:0]          node_index;
		logic [REAL_W-1:0]         node_real;
		logic signed [NOISE_W-1:0] node_noise;
		logic [IDX_W-1:0]          range_from;
		logic [IDX_W-1:0]          range_to;
	} item_t;

	typedef struct packed {
		logic [REAL_W-1:0]       real_sum;
		logic signed [SUM_W-1:0] noisy_sum;
		logic                    bad_range;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		ACT_LEFT,
		ACT_RIGHT,
		ACT_CLIMB,
		ACT_LAST
	} act_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic step;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_query;
		logic bad;
		act_t act;
	} sts_t;

endpackage

[rtl/core/kary_tree_range_sum_query.sv]
// ----------------------------------------------------------------------------
// kary_tree_range_sum_query: k-ary histogram tree with range sum queries
// Node writes and range queries over a stored tree of (real, noise) nodes.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low. Its
// single result shows on result for exactly one cycle with done high; there is
// no way to hold it off, so the receiver must take it in that cycle. A node
// write or a rejected query goes from decode straight to finish, and done is
// registered from finish. A valid query reads one tree node per cycle through
// the one read port of the node memory, except in the walk steps in which it
// climbs a level; drain and finish follow the walk. With a branch factor of
// four a wide range reads up to six nodes per level below the top, the top
// level reads every remaining node of the range, and a single level tree reads
// every leaf of the range. busy falls in the cycle that done shows, so the
// next item can be taken there. The node memory has no reset: reading a node
// that was never written gives an arbitrary sum. Config writes (leaf count,
// level count) are always taken and must only be made while the block is
// idle.
// ----------------------------------------------------------------------------
module kary_tree_range_sum_query (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ktrsq_pkg::item_t                  item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ktrsq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ktrsq_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                              done,
	output ktrsq_pkg::result_t                result
);

	// command and status between sequencer and datapath
	ktrsq_pkg::ctl_t ctl;
	ktrsq_pkg::sts_t sts;

	// sequencer: idle, decode, walk one node or level per cycle, drain, finish
	ktrsq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	// node memory, walk registers, accumulators and result register
	ktrsq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

[rtl/core/ktrsq_ctrl.sv]
// ----------------------------------------------------------------------------
// ktrsq_ctrl: sequencer of the k-ary range sum query block
// Steps an item through decode, walk and drain (valid queries only), result.
// ----------------------------------------------------------------------------
module ktrsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ktrsq_pkg::sts_t   sts,
	output ktrsq_pkg::ctl_t   ctl
);

	ktrsq_pkg::state_t state_q;
	ktrsq_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ktrsq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		unique case (state_q)
			ktrsq_pkg::ST_IDLE: begin
				if (start) begin
					ctl.load  = 1'b1;
					state_nxt = ktrsq_pkg::ST_DECODE;
				end
			end
			ktrsq_pkg::ST_DECODE: begin
				ctl.decode = 1'b1;
				if (sts.is_query && !sts.bad) begin
					state_nxt = ktrsq_pkg::ST_WALK;
				end else begin
					state_nxt = ktrsq_pkg::ST_FINISH;
				end
			end
			ktrsq_pkg::ST_WALK: begin
				ctl.step = 1'b1;
				if (sts.act == ktrsq_pkg::ACT_LAST) begin
					state_nxt = ktrsq_pkg::ST_DRAIN;
				end
			end
			// last read lands in the accumulator
			ktrsq_pkg::ST_DRAIN: begin
				state_nxt = ktrsq_pkg::ST_FINISH;
			end
			ktrsq_pkg::ST_FINISH: begin
				ctl.finish = 1'b1;
				state_nxt  = ktrsq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ktrsq_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ktrsq_pkg::ST_IDLE);

endmodule

[rtl/core/ktrsq_datapath.sv]
// ----------------------------------------------------------------------------
// ktrsq_datapath: node store, range walker and sum accumulators
// Holds the configuration, the tree memory and the result register.
// ----------------------------------------------------------------------------
module ktrsq_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ktrsq_pkg::ctl_t                      ctl,
	output ktrsq_pkg::sts_t                      sts,
	input  ktrsq_pkg::item_t                     item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ktrsq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ktrsq_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 done,
	output ktrsq_pkg::result_t                   result
);

	localparam int ACC_W   = ktrsq_pkg::ACC_W;
	localparam int SUM_W   = ktrsq_pkg::SUM_W;
	localparam int REAL_W  = ktrsq_pkg::REAL_W;
	localparam int NOISE_W = ktrsq_pkg::NOISE_W;
	localparam int LEAF_W  = ktrsq_pkg::LEAF_W;
	localparam int LVL_W   = ktrsq_pkg::LVL_W;
	localparam int IDX_W   = ktrsq_pkg::IDX_W;
	localparam int ADDR_W  = ktrsq_pkg::ADDR_W;

	logic [LEAF_W-1:0] leaf_count_q;
	logic [LVL_W-1:0]  level_count_q;
	logic [LEAF_W-1:0] eff_leaves;
	logic [LVL_W-1:0]  eff_levels;
	logic [LVL_W-1:0]  top;

	ktrsq_pkg::item_t item_q;
	logic [IDX_W-1:0] f_q;
	logic [IDX_W-1:0] t_q;
	logic [LVL_W-1:0] lvl_q;
	logic             bad_q;

	logic [ktrsq_pkg::CELL_W-1:0] mem [ktrsq_pkg::STORE_DEPTH];
	logic [ktrsq_pkg::CELL_W-1:0] rd_data_s1;
	logic                         rd_vld_s1;
	logic                         we;
	logic                         re;
	logic [ADDR_W-1:0]            waddr;
	logic [ADDR_W-1:0]            raddr;

	logic [ACC_W-1:0]        rs_q;
	logic signed [ACC_W-1:0] ns_q;
	logic [REAL_W-1:0]       rd_real;
	logic [NOISE_W-1:0]      rd_noise;

	logic                    is_query;
	logic                    wr_bad;
	logic                    q_bad;
	logic                    at_top;
	logic                    f_lt_t;
	logic                    go_left;
	logic                    go_right;
	ktrsq_pkg::act_t         act;

	logic signed [ACC_W:0]   noisy;
	logic                    noisy_ovf;
	logic [SUM_W-1:0]        noisy_sat;
	logic [REAL_W-1:0]       real_sat;

	ktrsq_pkg::result_t      result_q;
	logic                    done_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q  <= ktrsq_pkg::LEAF_RESET;
			level_count_q <= ktrsq_pkg::LEVEL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ktrsq_pkg::CFG_LEAF_COUNT:  leaf_count_q  <= cfg_data;
				ktrsq_pkg::CFG_LEVEL_COUNT: level_count_q <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_leaves = leaf_count_q;
		if (leaf_count_q == '0) begin
			eff_leaves = LEAF_W'(1);
		end else if (leaf_count_q > LEAF_W'(ktrsq_pkg::MAX_LEAVES)) begin
			eff_leaves = LEAF_W'(ktrsq_pkg::MAX_LEAVES);
		end
		eff_levels = level_count_q;
		if (level_count_q == '0) begin
			eff_levels = LVL_W'(1);
		end else if (level_count_q > LVL_W'(ktrsq_pkg::MAX_LEVELS)) begin
			eff_levels = LVL_W'(ktrsq_pkg::MAX_LEVELS);
		end
	end

	assign top = eff_levels - LVL_W'(1);

	// item checks
	assign is_query = (item_q.kind == ktrsq_pkg::KIND_QUERY);
	assign wr_bad   = (item_q.node_level >= eff_levels) ||
		(LEAF_W'(item_q.node_index) >= ktrsq_pkg::nodes_at(eff_leaves, item_q.node_level));
	assign q_bad    = (item_q.range_from > item_q.range_to) ||
		(LEAF_W'(item_q.range_to) >= eff_leaves);

	// walk decision: left edge, right edge, climb, then the meeting node
	assign at_top   = (lvl_q == top);
	assign f_lt_t   = (f_q < t_q);
	assign go_left  = (((f_q % ktrsq_pkg::BRANCH_IDX) != '0) || at_top) && f_lt_t;
	assign go_right = (((t_q % ktrsq_pkg::BRANCH_IDX) != ktrsq_pkg::BRANCH_LAST) || at_top)
		&& f_lt_t;

	always_comb begin
		if (go_left) begin
			act = ktrsq_pkg::ACT_LEFT;
		end else if (go_right) begin
			act = ktrsq_pkg::ACT_RIGHT;
		end else if ((f_q != t_q) && (lvl_q < top)) begin
			act = ktrsq_pkg::ACT_CLIMB;
		end else begin
			act = ktrsq_pkg::ACT_LAST;
		end
	end

	assign sts.is_query = is_query;
	assign sts.bad      = is_query ? q_bad : wr_bad;
	assign sts.act      = act;

	// item and walk registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
			f_q    <= item.range_from;
			t_q    <= item.range_to;
			lvl_q  <= '0;
		end else if (ctl.step) begin
			unique case (act)
				ktrsq_pkg::ACT_LEFT:  f_q <= f_q + IDX_W'(1);
				ktrsq_pkg::ACT_RIGHT: t_q <= t_q - IDX_W'(1);
				ktrsq_pkg::ACT_CLIMB: begin
					f_q   <= f_q / ktrsq_pkg::BRANCH_IDX;
					t_q   <= t_q / ktrsq_pkg::BRANCH_IDX;
					lvl_q <= lvl_q + LVL_W'(1);
				end
				ktrsq_pkg::ACT_LAST: ;
				default: ;
			endcase
		end
		if (ctl.decode) begin
			bad_q <= sts.bad;
		end
	end

	// node store
	assign we    = ctl.decode && !is_query && !wr_bad;
	assign waddr = ktrsq_pkg::base_of(item_q.node_level) + ADDR_W'(item_q.node_index);
	assign re    = ctl.step && (act != ktrsq_pkg::ACT_CLIMB);
	assign raddr = ktrsq_pkg::base_of(lvl_q) +
		ADDR_W'((act == ktrsq_pkg::ACT_RIGHT) ? t_q : f_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {item_q.node_real, item_q.node_noise};
		end
		if (re) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= re;
		end
	end

	// accumulators
	assign rd_real  = rd_data_s1[ktrsq_pkg::CELL_W-1:NOISE_W];
	assign rd_noise = rd_data_s1[NOISE_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rs_q <= '0;
			ns_q <= '0;
		end else if (rd_vld_s1) begin
			rs_q <= rs_q + ACC_W'(rd_real);
			ns_q <= ns_q + signed'({{(ACC_W-NOISE_W){rd_noise[NOISE_W-1]}}, rd_noise});
		end
	end

	// saturation
	assign noisy     = signed'({1'b0, rs_q}) + signed'({ns_q[ACC_W-1], ns_q});
	assign noisy_ovf = !(&noisy[ACC_W:SUM_W-1]) && (|noisy[ACC_W:SUM_W-1]);
	assign noisy_sat = noisy_ovf ?
		(noisy[ACC_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}}) :
		noisy[SUM_W-1:0];
	assign real_sat  = (|rs_q[ACC_W-1:REAL_W]) ? {REAL_W{1'b1}} : rs_q[REAL_W-1:0];

	// result register
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			result_q.real_sum  <= real_sat;
			result_q.noisy_sum <= signed'(noisy_sat);
			result_q.bad_range <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.finish;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/core/ktrsq_checker.sv]
// ----------------------------------------------------------------------------
// ktrsq_checker: port level checks of the k-ary range sum query block
// Item acceptance, result strobe and result contents over time.
// ----------------------------------------------------------------------------
module ktrsq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input ktrsq_pkg::result_t result
);

	// an accepted item keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result only follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work in progress");

	// the block is free again when its result shows
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result shows");

	// one item gives one single-cycle strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a flagged item carries zero sums
	assert property (@(posedge clk) disable iff (!arst_n)
		done && result.bad_range |-> (result.real_sum == '0) && (result.noisy_sum == '0))
		else $error("flagged item with nonzero sums");

endmodule

bind kary_tree_range_sum_query ktrsq_checker u_ktrsq_checker (.*);
